### hdl/accumulator_cpu_core_macros.svh
// assertion macros used by the checker file of the accumulator cpu core
// expects clk and arst_n in scope where a macro is used
`ifndef ACCUMULATOR_CPU_CORE_MACROS_SVH
`define ACCUMULATOR_CPU_CORE_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ACC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is asserted
`define ACC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/acc_cpu_pkg.sv
// types and constants of the accumulator cpu core
// no dependencies; used by every module of the core
`timescale 1ns / 1ps

package acc_cpu_pkg;

	// request codes
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_EXEC  = 2'd2;

	// opcodes
	localparam logic [7:0] OP_NOP  = 8'd0;
	localparam logic [7:0] OP_LDAC = 8'd1;
	localparam logic [7:0] OP_STAC = 8'd2;
	localparam logic [7:0] OP_MVAC = 8'd3;
	localparam logic [7:0] OP_MOVR = 8'd4;
	localparam logic [7:0] OP_ADD  = 8'd8;
	localparam logic [7:0] OP_SUB  = 8'd9;
	localparam logic [7:0] OP_INAC = 8'd10;
	localparam logic [7:0] OP_CLAC = 8'd11;
	localparam logic [7:0] OP_AND  = 8'd12;
	localparam logic [7:0] OP_OR   = 8'd13;
	localparam logic [7:0] OP_XOR  = 8'd14;
	localparam logic [7:0] OP_NOT  = 8'd15;
	localparam logic [7:0] OP_MVI  = 8'd22;
	localparam logic [7:0] OP_HALT = 8'd255;

	// flag bit positions
	localparam int FLAG_Z = 0;
	localparam int FLAG_C = 1;
	localparam int FLAG_V = 2;
	localparam int FLAG_N = 3;

	localparam logic [7:0] BYTE_MAX = 8'd255;
	localparam logic [7:0] SBYTE_MAX = 8'd127;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] mem_addr;
		logic [7:0]  mem_data;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  read_byte;
		logic [7:0]  accumulator;
		logic [7:0]  general_reg;
		logic [3:0]  flag_bits;
		logic [15:0] program_counter;
		logic [15:0] address_reg;
		logic [7:0]  data_reg;
		logic [7:0]  executed_op;
		logic        bad_opcode;
		logic        is_halted;
	} result_t;

	// register file view handed to and returned by the alu
	typedef struct packed {
		logic [7:0] acc;
		logic [7:0] rg;
		logic [3:0] flags;
	} alu_regs_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MEMWR,
		S_MEMRD,
		S_RDCAP,
		S_FETCH,
		S_DECODE,
		S_ADDR_HI,
		S_ADDR_LO,
		S_OPER,
		S_DONE
	} state_t;

endpackage

### hdl/acc_cpu_alu.sv
// combinational register-to-register unit of the accumulator cpu core
// depends on acc_cpu_pkg
`timescale 1ns / 1ps

module acc_cpu_alu (
	input  logic [7:0]              op,
	input  acc_cpu_pkg::alu_regs_t  cur,
	output acc_cpu_pkg::alu_regs_t  nxt
);

	logic [8:0] sum;
	logic [7:0] diff;
	logic [7:0] inc;
	logic [7:0] logic_res;

	assign sum  = {1'b0, cur.acc} + {1'b0, cur.rg};
	assign diff = cur.acc - cur.rg;
	assign inc  = cur.acc + 8'd1;

	always_comb begin
		case (op)
			acc_cpu_pkg::OP_AND: logic_res = cur.acc & cur.rg;
			acc_cpu_pkg::OP_OR:  logic_res = cur.acc | cur.rg;
			acc_cpu_pkg::OP_XOR: logic_res = cur.acc ^ cur.rg;
			default:             logic_res = ~cur.acc;
		endcase
	end

	always_comb begin
		nxt = cur;
		case (op)
			acc_cpu_pkg::OP_MVAC: nxt.rg = cur.acc;
			acc_cpu_pkg::OP_MOVR: nxt.acc = cur.rg;
			acc_cpu_pkg::OP_ADD: begin
				nxt.acc = sum[7:0];
				nxt.flags[acc_cpu_pkg::FLAG_Z] = (sum[7:0] == 8'd0);
				nxt.flags[acc_cpu_pkg::FLAG_N] = sum[7];
				nxt.flags[acc_cpu_pkg::FLAG_C] = sum[8];
				nxt.flags[acc_cpu_pkg::FLAG_V] = ~(cur.acc[7] ^ cur.rg[7]) & (cur.acc[7] ^ sum[7]);
			end
			acc_cpu_pkg::OP_SUB: begin
				nxt.acc = diff;
				nxt.flags[acc_cpu_pkg::FLAG_Z] = (diff == 8'd0);
				nxt.flags[acc_cpu_pkg::FLAG_N] = diff[7];
				// carry means no borrow
				nxt.flags[acc_cpu_pkg::FLAG_C] = (cur.acc >= cur.rg);
				nxt.flags[acc_cpu_pkg::FLAG_V] = (cur.acc[7] ^ cur.rg[7]) & (cur.acc[7] ^ diff[7]);
			end
			acc_cpu_pkg::OP_INAC: begin
				nxt.acc = inc;
				nxt.flags[acc_cpu_pkg::FLAG_Z] = (inc == 8'd0);
				nxt.flags[acc_cpu_pkg::FLAG_N] = inc[7];
				nxt.flags[acc_cpu_pkg::FLAG_C] = (cur.acc == acc_cpu_pkg::BYTE_MAX);
				nxt.flags[acc_cpu_pkg::FLAG_V] = (cur.acc == acc_cpu_pkg::SBYTE_MAX);
			end
			acc_cpu_pkg::OP_CLAC: begin
				nxt.acc = 8'd0;
				nxt.flags = 4'd0;
				nxt.flags[acc_cpu_pkg::FLAG_Z] = 1'b1;
			end
			acc_cpu_pkg::OP_AND, acc_cpu_pkg::OP_OR, acc_cpu_pkg::OP_XOR,
			acc_cpu_pkg::OP_NOT: begin
				// logic ops keep carry and overflow
				nxt.acc = logic_res;
				nxt.flags[acc_cpu_pkg::FLAG_Z] = (logic_res == 8'd0);
				nxt.flags[acc_cpu_pkg::FLAG_N] = logic_res[7];
			end
			default: nxt = cur;
		endcase
	end

endmodule

### hdl/accumulator_cpu_core.sv
// top level of the accumulator cpu core: sequencer, registers and byte memory
// depends on acc_cpu_pkg and acc_cpu_alu
`timescale 1ns / 1ps

// channel   ports                  direction  qualifier
// command   start, busy, cmd       in         start high while busy low
// result    done, result           out        done high for one cycle
//
// path to done: write memwr; read memrd, rdcap; alu/nop/halt/undefined fetch, decode;
// mvi adds oper, stac addr_hi and addr_lo, ldac all three; execute while halted or
// unused code goes straight to done. busy then drops before the next word is taken.
// the order is set by the single memory port: fetch, two address bytes and the data
// access follow one another. reset clears the state and cpu registers; memory needs
// no clearing pass. the receiver cannot stall: each result word shows for exactly one cycle.

module accumulator_cpu_core #(
	parameter int ADDR_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  acc_cpu_pkg::cmd_t      cmd,
	output logic                   busy,
	output logic                   done,
	output acc_cpu_pkg::result_t   result
);

	localparam int MEM_DEPTH = 1 << ADDR_BITS;

	acc_cpu_pkg::state_t state_q, state_nxt;
	acc_cpu_pkg::cmd_t   cmd_q;

	logic [7:0]           acc_q, reg_q, dr_q, ir_q, tr_q, rd_q, op_q;
	logic [3:0]           flags_q;
	logic [ADDR_BITS-1:0] pc_q, ar_q;
	logic                 halted_q, bad_q;

	logic [7:0]           mem_q [0:MEM_DEPTH-1];
	logic [7:0]           mem_rdata_q;
	logic [ADDR_BITS-1:0] mem_addr_c;
	logic [7:0]           mem_wdata_c;
	logic                 mem_we_c;

	logic [15:0]          target_full;
	logic [ADDR_BITS-1:0] target_addr;
	logic                 accept;

	acc_cpu_pkg::alu_regs_t alu_cur, alu_nxt;

	assign accept = start && !busy;
	assign target_full = {tr_q, mem_rdata_q};
	assign target_addr = target_full[ADDR_BITS-1:0];

	assign alu_cur.acc   = acc_q;
	assign alu_cur.rg    = reg_q;
	assign alu_cur.flags = flags_q;

	acc_cpu_alu u_alu (
		.op  (mem_rdata_q),
		.cur (alu_cur),
		.nxt (alu_nxt)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			acc_cpu_pkg::S_IDLE: begin
				if (start) begin
					case (cmd.req_type)
						acc_cpu_pkg::REQ_WRITE: state_nxt = acc_cpu_pkg::S_MEMWR;
						acc_cpu_pkg::REQ_READ:  state_nxt = acc_cpu_pkg::S_MEMRD;
						acc_cpu_pkg::REQ_EXEC:
							state_nxt = halted_q ? acc_cpu_pkg::S_DONE : acc_cpu_pkg::S_FETCH;
						default: state_nxt = acc_cpu_pkg::S_DONE;
					endcase
				end
			end
			acc_cpu_pkg::S_MEMWR:  state_nxt = acc_cpu_pkg::S_DONE;
			acc_cpu_pkg::S_MEMRD:  state_nxt = acc_cpu_pkg::S_RDCAP;
			acc_cpu_pkg::S_RDCAP:  state_nxt = acc_cpu_pkg::S_DONE;
			acc_cpu_pkg::S_FETCH:  state_nxt = acc_cpu_pkg::S_DECODE;
			acc_cpu_pkg::S_DECODE: begin
				case (mem_rdata_q)
					acc_cpu_pkg::OP_LDAC, acc_cpu_pkg::OP_STAC:
						state_nxt = acc_cpu_pkg::S_ADDR_HI;
					acc_cpu_pkg::OP_MVI: state_nxt = acc_cpu_pkg::S_OPER;
					default:             state_nxt = acc_cpu_pkg::S_DONE;
				endcase
			end
			acc_cpu_pkg::S_ADDR_HI: state_nxt = acc_cpu_pkg::S_ADDR_LO;
			acc_cpu_pkg::S_ADDR_LO:
				state_nxt = (ir_q == acc_cpu_pkg::OP_STAC) ? acc_cpu_pkg::S_DONE
				                                           : acc_cpu_pkg::S_OPER;
			acc_cpu_pkg::S_OPER: state_nxt = acc_cpu_pkg::S_DONE;
			acc_cpu_pkg::S_DONE: state_nxt = acc_cpu_pkg::S_IDLE;
			default:             state_nxt = acc_cpu_pkg::S_IDLE;
		endcase
	end

	// outputs and memory port control
	always_comb begin
		busy        = (state_q != acc_cpu_pkg::S_IDLE);
		done        = (state_q == acc_cpu_pkg::S_DONE);
		mem_we_c    = 1'b0;
		mem_wdata_c = cmd_q.mem_data;
		mem_addr_c  = pc_q;
		case (state_q)
			acc_cpu_pkg::S_MEMWR: begin
				mem_we_c   = 1'b1;
				mem_addr_c = cmd_q.mem_addr[ADDR_BITS-1:0];
			end
			acc_cpu_pkg::S_MEMRD:   mem_addr_c = cmd_q.mem_addr[ADDR_BITS-1:0];
			acc_cpu_pkg::S_FETCH:   mem_addr_c = pc_q;
			// operand read-ahead at ar, used only by ops that take operands
			acc_cpu_pkg::S_DECODE:  mem_addr_c = ar_q;
			acc_cpu_pkg::S_ADDR_HI: mem_addr_c = ar_q;
			acc_cpu_pkg::S_ADDR_LO: begin
				mem_addr_c  = target_addr;
				mem_wdata_c = acc_q;
				mem_we_c    = (ir_q == acc_cpu_pkg::OP_STAC);
			end
			default: mem_addr_c = pc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we_c) begin
			mem_q[mem_addr_c] <= mem_wdata_c;
		end
		mem_rdata_q <= mem_q[mem_addr_c];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= acc_cpu_pkg::S_IDLE;
			acc_q    <= '0;
			reg_q    <= '0;
			flags_q  <= '0;
			pc_q     <= '0;
			ar_q     <= '0;
			dr_q     <= '0;
			ir_q     <= '0;
			tr_q     <= '0;
			halted_q <= 1'b0;
			rd_q     <= '0;
			op_q     <= '0;
			bad_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				acc_cpu_pkg::S_IDLE: begin
					if (start) begin
						rd_q  <= '0;
						op_q  <= '0;
						bad_q <= 1'b0;
					end
				end
				acc_cpu_pkg::S_RDCAP: rd_q <= mem_rdata_q;
				acc_cpu_pkg::S_FETCH: begin
					pc_q <= pc_q + ADDR_BITS'(1);
					ar_q <= pc_q + ADDR_BITS'(1);
				end
				acc_cpu_pkg::S_DECODE: begin
					dr_q <= mem_rdata_q;
					ir_q <= mem_rdata_q;
					op_q <= mem_rdata_q;
					case (mem_rdata_q)
						acc_cpu_pkg::OP_LDAC, acc_cpu_pkg::OP_STAC, acc_cpu_pkg::OP_MVI: begin
							pc_q <= pc_q + ADDR_BITS'(1);
							ar_q <= ar_q + ADDR_BITS'(1);
						end
						acc_cpu_pkg::OP_MVAC, acc_cpu_pkg::OP_MOVR, acc_cpu_pkg::OP_ADD,
						acc_cpu_pkg::OP_SUB, acc_cpu_pkg::OP_INAC, acc_cpu_pkg::OP_CLAC,
						acc_cpu_pkg::OP_AND, acc_cpu_pkg::OP_OR, acc_cpu_pkg::OP_XOR,
						acc_cpu_pkg::OP_NOT: begin
							acc_q   <= alu_nxt.acc;
							reg_q   <= alu_nxt.rg;
							flags_q <= alu_nxt.flags;
						end
						acc_cpu_pkg::OP_NOP:  halted_q <= halted_q;
						acc_cpu_pkg::OP_HALT: halted_q <= 1'b1;
						default:              bad_q <= 1'b1;
					endcase
				end
				acc_cpu_pkg::S_ADDR_HI: begin
					tr_q <= mem_rdata_q;
					dr_q <= mem_rdata_q;
					pc_q <= pc_q + ADDR_BITS'(1);
				end
				acc_cpu_pkg::S_ADDR_LO: begin
					ar_q <= target_addr;
					dr_q <= (ir_q == acc_cpu_pkg::OP_STAC) ? acc_q : mem_rdata_q;
				end
				acc_cpu_pkg::S_OPER: begin
					dr_q  <= mem_rdata_q;
					acc_q <= mem_rdata_q;
				end
				default: rd_q <= rd_q;
			endcase
		end
	end

	always_comb begin
		result.read_byte       = rd_q;
		result.accumulator     = acc_q;
		result.general_reg     = reg_q;
		result.flag_bits       = flags_q;
		result.program_counter = 16'(pc_q);
		result.address_reg     = 16'(ar_q);
		result.data_reg        = dr_q;
		result.executed_op     = op_q;
		result.bad_opcode      = bad_q;
		result.is_halted       = halted_q;
	end

endmodule

### hdl/acc_cpu_checker.sv
// port-level checks for the accumulator cpu core, bound to the top level
// depends on acc_cpu_pkg and accumulator_cpu_core_macros.svh
`timescale 1ns / 1ps
`include "accumulator_cpu_core_macros.svh"

module acc_cpu_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input acc_cpu_pkg::cmd_t     cmd,
	input logic                  busy,
	input logic                  done,
	input acc_cpu_pkg::result_t  result
);

	logic mem_req;

	// a byte write or read always accesses the memory port before its result word
	assign mem_req = start && !busy &&
		(cmd.req_type == acc_cpu_pkg::REQ_WRITE || cmd.req_type == acc_cpu_pkg::REQ_READ);

	`ACC_ASSERT_NOW(a_done_busy, done, busy, "result word outside a busy period")
	`ACC_ASSERT_NEXT(a_done_frees, done, !busy && !done, "core still busy after result word")
	`ACC_ASSERT_NEXT(a_halt_sticks, result.is_halted, result.is_halted, "halt state was lost")
	`ACC_ASSERT_NOW(a_bad_has_op, done && result.bad_opcode, result.executed_op != acc_cpu_pkg::OP_NOP, "undefined opcode flagged without a fetched opcode")
	`ACC_ASSERT_NEXT(a_mem_req_runs, mem_req, busy && !done, "memory request finished without its access cycle")

endmodule

bind accumulator_cpu_core acc_cpu_checker u_acc_cpu_checker (.*);
